### hw/rtl/plq_pkg.sv
// shared constants, codes and types of the per-link queue polling scheduler
`timescale 1ns / 1ps
package plq_pkg;

    localparam int NUM_QUEUES  = 8;
    localparam int QUEUE_DEPTH = 8;

    // field widths fixed by the interface
    localparam int TAG_W     = 16;
    localparam int NODE_W    = 4;
    localparam int ACT_W     = 2;
    localparam int QOUT_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int ENTRY_W   = TAG_W + NODE_W;

    // derived widths
    localparam int QW    = $clog2(NUM_QUEUES);
    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int FW    = $clog2(QUEUE_DEPTH + 1);
    localparam int AW    = $clog2(NUM_QUEUES * QUEUE_DEPTH);
    localparam int TW    = $clog2(NUM_QUEUES * QUEUE_DEPTH + 1);
    localparam int SCW   = $clog2(NUM_QUEUES + 1);
    localparam int CMP_W = ((NODE_W > SCW) ? NODE_W : SCW) + 1;

    // action codes
    localparam logic [ACT_W-1:0] ACT_ARRIVE    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOCAL     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SEND_DONE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OWN_NODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINKS_IN_USE = 2'd1;

    // configuration reset values
    localparam logic [NODE_W-1:0] OWN_NODE_RST     = 4'd1;
    localparam logic [NODE_W-1:0] LINKS_IN_USE_RST = 4'd8;

    typedef enum logic [1:0] {
        V_FORWARD = 2'd0,
        V_CONSUME = 2'd1,
        V_DROP    = 2'd2
    } t_verdict;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_SCAN,
        S_READ,
        S_POP,
        S_FLUSH_MORE,
        S_FLUSH_LAST
    } t_state;

    typedef struct packed {
        logic               wr_en;
        logic [AW-1:0]      wr_addr;
        logic [ENTRY_W-1:0] wr_data;
        logic               rd_en;
        logic [AW-1:0]      rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic              push;
        logic [TAG_W-1:0]  tag;
        logic [NODE_W-1:0] dest;
        logic [QOUT_W-1:0] queue;
        t_verdict          verdict;
        logic              last;
    } t_result;

endpackage

### hw/rtl/plq_store.sv
// packet store shared by all link queues, one write and one registered read port
`timescale 1ns / 1ps
module plq_store (
    input  logic                          i_clk,
    input  plq_pkg::t_mem_req             i_req,
    output logic [plq_pkg::ENTRY_W-1:0]   o_rd_data
);
    import plq_pkg::*;

    logic [ENTRY_W-1:0] r_mem [NUM_QUEUES*QUEUE_DEPTH];
    logic [ENTRY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/plq_ctrl.sv
// sequencer: enqueue, one-queue-per-cycle round-robin scan, pop and result staging
`timescale 1ns / 1ps
module plq_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [plq_pkg::ACT_W-1:0]      i_action,
    input  logic [plq_pkg::NODE_W-1:0]     i_source_link,
    input  logic [plq_pkg::TAG_W-1:0]      i_packet_tag,
    input  logic [plq_pkg::NODE_W-1:0]     i_destination,
    input  logic                           i_cfg_valid,
    input  logic [plq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [plq_pkg::NODE_W-1:0]     i_cfg_data,
    input  logic                           i_out_free,
    output plq_pkg::t_result               o_res,
    output plq_pkg::t_mem_req              o_mem,
    input  logic [plq_pkg::ENTRY_W-1:0]    i_rd_data
);
    import plq_pkg::*;

    function automatic logic [CMP_W-1:0] clamp_node(input logic [CMP_W-1:0] v,
                                                    input logic [CMP_W-1:0] lc);
        logic [CMP_W-1:0] r;
        r = v;
        if (r < CMP_W'(1)) r = CMP_W'(1);
        if (r > lc) r = lc;
        return r;
    endfunction

    t_state r_state, n_state;

    logic [NODE_W-1:0] r_own_node, r_links;
    logic [ACT_W-1:0]  r_act, n_act;
    logic [NODE_W-1:0] r_link, n_link;
    logic [TAG_W-1:0]  r_tag, n_tag;
    logic [NODE_W-1:0] r_dest, n_dest;

    logic [PW-1:0] r_head [NUM_QUEUES];
    logic [PW-1:0] n_head [NUM_QUEUES];
    logic [FW-1:0] r_fill [NUM_QUEUES];
    logic [FW-1:0] n_fill [NUM_QUEUES];
    logic [TW-1:0] r_total, n_total;
    logic [QW-1:0] r_serving, n_serving;
    logic [QW-1:0] r_scan_q, n_scan_q;
    logic [SCW-1:0] r_scan_cnt, n_scan_cnt;
    logic r_idle, n_idle;

    logic              r_hold_valid, n_hold_valid;
    logic [TAG_W-1:0]  r_hold_tag, n_hold_tag;
    logic [NODE_W-1:0] r_hold_dest, n_hold_dest;
    logic [QW-1:0]     r_hold_queue, n_hold_queue;
    t_verdict          r_hold_verdict, n_hold_verdict;

    logic [CMP_W-1:0] w_lc, w_links_ext, w_me, w_enq_node;
    logic [QW-1:0]    w_enq_q, w_idx, w_scan_next;
    logic [FW-1:0]    w_fill_at;
    logic [PW-1:0]    w_head_at, w_wr_pos, w_head_next;
    logic [FW:0]      w_pos_sum;
    logic [PW:0]      w_head_inc;
    logic [CMP_W-1:0] w_scan_inc;
    logic             w_is_enq, w_full, w_scan_hit, w_scan_miss, w_consume;
    logic [AW-1:0]    w_wr_addr, w_rd_addr;
    logic [TAG_W-1:0] w_rd_tag;
    logic [NODE_W-1:0] w_rd_dest;

    // clamped link count and own number
    always_comb begin
        w_links_ext = CMP_W'(r_links);
        if (w_links_ext < CMP_W'(2)) begin
            w_lc = CMP_W'(2);
        end else if (w_links_ext > CMP_W'(NUM_QUEUES)) begin
            w_lc = CMP_W'(NUM_QUEUES);
        end else begin
            w_lc = w_links_ext;
        end
        w_me       = clamp_node(CMP_W'(r_own_node), w_lc);
        w_enq_node = clamp_node((r_act == ACT_ARRIVE) ? CMP_W'(r_link) : CMP_W'(r_own_node),
                                w_lc);
        w_enq_q    = QW'(w_enq_node - CMP_W'(1));
        w_is_enq   = (r_act == ACT_ARRIVE) || (r_act == ACT_LOCAL);
    end

    // one queue index per cycle into the head and fill tables
    always_comb begin
        case (r_state)
            S_DISP:  w_idx = w_enq_q;
            S_SCAN:  w_idx = r_scan_q;
            default: w_idx = r_serving;
        endcase
        w_fill_at = r_fill[w_idx];
        w_head_at = r_head[w_idx];
    end

    always_comb begin
        w_full    = w_fill_at >= FW'(QUEUE_DEPTH);
        w_pos_sum = (FW+1)'(w_head_at) + (FW+1)'(w_fill_at);
        if (w_pos_sum >= (FW+1)'(QUEUE_DEPTH)) begin
            w_wr_pos = PW'(w_pos_sum - (FW+1)'(QUEUE_DEPTH));
        end else begin
            w_wr_pos = PW'(w_pos_sum);
        end
        w_wr_addr = AW'(w_enq_q) * AW'(QUEUE_DEPTH) + AW'(w_wr_pos);
        w_rd_addr = AW'(r_serving) * AW'(QUEUE_DEPTH) + AW'(w_head_at);

        w_head_inc  = (PW+1)'(w_head_at) + (PW+1)'(1);
        w_head_next = (w_head_inc >= (PW+1)'(QUEUE_DEPTH)) ? '0 : PW'(w_head_inc);

        w_scan_inc  = CMP_W'(r_scan_q) + CMP_W'(1);
        w_scan_next = (w_scan_inc >= w_lc) ? '0 : QW'(w_scan_inc);
        w_scan_hit  = (r_total != '0) && (w_fill_at != '0);
        w_scan_miss = (r_total == '0) ||
                      ((w_fill_at == '0) && (r_scan_cnt == SCW'(NUM_QUEUES)));

        w_rd_tag  = i_rd_data[TAG_W-1:0];
        w_rd_dest = i_rd_data[ENTRY_W-1:TAG_W];
        w_consume = (CMP_W'(w_rd_dest) == w_me);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISP;
            end
            S_DISP: begin
                if (w_is_enq) begin
                    if (w_full) n_state = S_FLUSH_LAST;
                    else if (r_idle) n_state = S_SCAN;
                    else n_state = S_IDLE;
                end else if ((r_act == ACT_SEND_DONE) && !r_idle) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (w_scan_miss) begin
                    n_state = r_hold_valid ? S_FLUSH_LAST : S_IDLE;
                end else if (w_scan_hit) begin
                    n_state = r_hold_valid ? S_FLUSH_MORE : S_READ;
                end
            end
            S_READ: n_state = S_POP;
            S_POP: begin
                n_state = w_consume ? S_SCAN : S_FLUSH_LAST;
            end
            S_FLUSH_MORE: begin
                if (i_out_free) n_state = S_READ;
            end
            S_FLUSH_LAST: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_act          = r_act;
        n_link         = r_link;
        n_tag          = r_tag;
        n_dest         = r_dest;
        n_head         = r_head;
        n_fill         = r_fill;
        n_total        = r_total;
        n_serving      = r_serving;
        n_scan_q       = r_scan_q;
        n_scan_cnt     = r_scan_cnt;
        n_idle         = r_idle;
        n_hold_valid   = r_hold_valid;
        n_hold_tag     = r_hold_tag;
        n_hold_dest    = r_hold_dest;
        n_hold_queue   = r_hold_queue;
        n_hold_verdict = r_hold_verdict;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act  = i_action;
                    n_link = i_source_link;
                    n_tag  = i_packet_tag;
                    n_dest = i_destination;
                end
            end
            S_DISP: begin
                if (w_is_enq) begin
                    if (w_full) begin
                        n_hold_valid   = 1'b1;
                        n_hold_tag     = r_tag;
                        n_hold_dest    = r_dest;
                        n_hold_queue   = w_enq_q;
                        n_hold_verdict = V_DROP;
                    end else begin
                        n_fill[w_enq_q] = w_fill_at + FW'(1);
                        n_total         = r_total + TW'(1);
                        if (r_idle) begin
                            n_idle     = 1'b0;
                            n_serving  = w_enq_q;
                            n_scan_q   = w_enq_q;
                            n_scan_cnt = '0;
                        end
                    end
                end else if ((r_act == ACT_SEND_DONE) && !r_idle) begin
                    n_scan_q   = r_serving;
                    n_scan_cnt = '0;
                end
            end
            S_SCAN: begin
                if (w_scan_miss) begin
                    n_idle = 1'b1;
                end else if (w_scan_hit) begin
                    n_serving = r_scan_q;
                end else begin
                    n_scan_q   = w_scan_next;
                    n_scan_cnt = r_scan_cnt + SCW'(1);
                end
            end
            S_POP: begin
                n_head[r_serving] = w_head_next;
                n_fill[r_serving] = w_fill_at - FW'(1);
                n_total           = r_total - TW'(1);
                n_hold_valid      = 1'b1;
                n_hold_tag        = w_rd_tag;
                n_hold_dest       = w_rd_dest;
                n_hold_queue      = r_serving;
                n_hold_verdict    = w_consume ? V_CONSUME : V_FORWARD;
                if (w_consume) begin
                    n_scan_q   = r_serving;
                    n_scan_cnt = '0;
                end
            end
            S_FLUSH_MORE, S_FLUSH_LAST: begin
                if (i_out_free) n_hold_valid = 1'b0;
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready    = (r_state == S_IDLE);
        o_mem.wr_en   = (r_state == S_DISP) && w_is_enq && !w_full;
        o_mem.wr_addr = w_wr_addr;
        o_mem.wr_data = {r_dest, r_tag};
        o_mem.rd_en   = (r_state == S_READ);
        o_mem.rd_addr = w_rd_addr;
        o_res.push    = ((r_state == S_FLUSH_MORE) || (r_state == S_FLUSH_LAST)) && i_out_free;
        o_res.tag     = r_hold_tag;
        o_res.dest    = r_hold_dest;
        o_res.queue   = QOUT_W'(r_hold_queue);
        o_res.verdict = r_hold_verdict;
        o_res.last    = (r_state == S_FLUSH_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_own_node   <= OWN_NODE_RST;
            r_links      <= LINKS_IN_USE_RST;
            r_head       <= '{default: '0};
            r_fill       <= '{default: '0};
            r_total      <= '0;
            r_serving    <= '0;
            r_scan_q     <= '0;
            r_scan_cnt   <= '0;
            r_idle       <= 1'b1;
            r_hold_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_fill       <= n_fill;
            r_total      <= n_total;
            r_serving    <= n_serving;
            r_scan_q     <= n_scan_q;
            r_scan_cnt   <= n_scan_cnt;
            r_idle       <= n_idle;
            r_hold_valid <= n_hold_valid;
            if (i_cfg_valid && (i_cfg_index == REG_OWN_NODE)) begin
                r_own_node <= i_cfg_data;
            end
            if (i_cfg_valid && (i_cfg_index == REG_LINKS_IN_USE)) begin
                r_links <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act          <= n_act;
        r_link         <= n_link;
        r_tag          <= n_tag;
        r_dest         <= n_dest;
        r_hold_tag     <= n_hold_tag;
        r_hold_dest    <= n_hold_dest;
        r_hold_queue   <= n_hold_queue;
        r_hold_verdict <= n_hold_verdict;
    end

endmodule

### hw/rtl/per_link_queue_polling_scheduler.sv
// top level of the per-link queue polling scheduler with its output register
//
// channel  direction  handshake                  payload
// input    in         i_in_valid / o_in_ready    i_action, i_source_link, i_packet_tag,
//                                                i_destination
// output   out        o_out_valid / i_out_ready  o_served_tag, o_served_destination,
//                                                o_served_queue, o_verdict, o_last_of_run
// config   in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// an input transaction holds the block for its whole run; ready again after the run
// enqueue while busy, ignored send-done: accept, dispatch; full-queue drop: also a result
// each served packet: a scan (one queue per cycle through the shared compare), a memory
//   read, a pop and a result step
// a forward run of one packet thus passes accept, dispatch, scan, read, pop and result;
//   consumed packets add a scan, read, pop and result each
// results wait in one output register; a stalled output only holds the result step
// synchronous active-low reset; no clearing pass, the packet store is never read unwritten
`timescale 1ns / 1ps
module per_link_queue_polling_scheduler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input transactions
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [plq_pkg::ACT_W-1:0]      i_action,
    input  logic [plq_pkg::NODE_W-1:0]     i_source_link,
    input  logic [plq_pkg::TAG_W-1:0]      i_packet_tag,
    input  logic [plq_pkg::NODE_W-1:0]     i_destination,
    // result transactions
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [plq_pkg::TAG_W-1:0]      o_served_tag,
    output logic [plq_pkg::NODE_W-1:0]     o_served_destination,
    output logic [plq_pkg::QOUT_W-1:0]     o_served_queue,
    output logic [1:0]                     o_verdict,
    output logic                           o_last_of_run,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [plq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [plq_pkg::NODE_W-1:0]     i_cfg_data
);
    import plq_pkg::*;

    t_result            w_res;
    t_mem_req           w_mem;
    logic [ENTRY_W-1:0] w_rd_data;
    logic               w_out_free;

    logic              r_out_valid;
    logic [TAG_W-1:0]  r_out_tag;
    logic [NODE_W-1:0] r_out_dest;
    logic [QOUT_W-1:0] r_out_queue;
    t_verdict          r_out_verdict;
    logic              r_out_last;

    // config writes are always taken, the registers sit in the sequencer
    assign o_cfg_ready = 1'b1;

    // the output register may take a new result when empty or being drained
    assign w_out_free = !r_out_valid || i_out_ready;

    plq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_source_link (i_source_link),
        .i_packet_tag  (i_packet_tag),
        .i_destination (i_destination),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_free    (w_out_free),
        .o_res         (w_res),
        .o_mem         (w_mem),
        .i_rd_data     (w_rd_data)
    );

    // one flat store, queue q owns entries q*QUEUE_DEPTH to q*QUEUE_DEPTH+QUEUE_DEPTH-1
    plq_store u_store (
        .i_clk     (i_clk),
        .i_req     (w_mem),
        .o_rd_data (w_rd_data)
    );

    // result register: valid is control, payload loads only on a push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.push) begin
            r_out_tag     <= w_res.tag;
            r_out_dest    <= w_res.dest;
            r_out_queue   <= w_res.queue;
            r_out_verdict <= w_res.verdict;
            r_out_last    <= w_res.last;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_served_tag         = r_out_tag;
    assign o_served_destination = r_out_dest;
    assign o_served_queue       = r_out_queue;
    assign o_verdict            = r_out_verdict;
    assign o_last_of_run        = r_out_last;

`ifndef ASSERT_OFF
    // the sequencer never overwrites a result that is still waiting
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.push |-> w_out_free)
        else $error("result pushed into a full output register");

    // the block is never ready in the cycle after it accepts a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("block ready right after accepting a transaction");

    // a drop ends its run
    a_drop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_out_verdict == V_DROP)) |-> o_last_of_run)
        else $error("drop result not marked last");

    // a forward ends its run, the block then waits for send-done
    a_forward_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_out_verdict == V_FORWARD)) |-> o_last_of_run)
        else $error("forward result not marked last");
`endif

endmodule

### test/per_link_queue_polling_scheduler_tb.sv
// self-checking testbench of the per-link queue polling scheduler
`timescale 1ns / 1ps
module per_link_queue_polling_scheduler_tb;
    import plq_pkg::*;

    // action code with no meaning, the block must ignore it
    localparam logic [ACT_W-1:0]     ACT_IGNORED  = 2'd3;
    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    localparam int IDLE_PCT        = 9;     // chance of a gap on either side
    localparam int SETTLE_CYCLES   = 24;    // covers a full scan plus a result step
    localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transaction at all
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 28;

    // one expected or observed result transaction
    typedef struct {
        logic [TAG_W-1:0]  tag;
        logic [NODE_W-1:0] dest;
        logic [QOUT_W-1:0] queue;
        t_verdict          verdict;
        logic              last;
    } t_served;

    // clock, reset and block inputs, all known from time zero
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic [ACT_W-1:0]     i_action      = '0;
    logic [NODE_W-1:0]    i_source_link = '0;
    logic [TAG_W-1:0]     i_packet_tag  = '0;
    logic [NODE_W-1:0]    i_destination = '0;
    logic                 i_out_ready   = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [NODE_W-1:0]    i_cfg_data    = '0;

    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [TAG_W-1:0]     o_served_tag;
    logic [NODE_W-1:0]    o_served_destination;
    logic [QOUT_W-1:0]    o_served_queue;
    logic [1:0]           o_verdict;
    logic                 o_last_of_run;
    logic                 o_cfg_ready;

    // scheduler shadow: queues, service position and registers
    logic [ENTRY_W-1:0]   pkt_mem [NUM_QUEUES][QUEUE_DEPTH];
    int unsigned          q_head [NUM_QUEUES];
    int unsigned          q_fill [NUM_QUEUES];
    int unsigned          pending_pkts;
    int unsigned          serve_q;
    bit                   sched_idle;
    logic [NODE_W-1:0]    own_node_reg;
    logic [NODE_W-1:0]    links_reg;

    t_served              run_results [$];     // results of the item in hand
    t_served              expected_served [$]; // results still to come out

    // run bookkeeping
    bit                   steady_run;          // no gaps on either side
    int unsigned          quiet_cycles;
    int unsigned          fail_count;
    int unsigned          items_sent;
    int unsigned          cfg_writes;
    int unsigned          forwards_seen;
    int unsigned          consumes_seen;
    int unsigned          drops_seen;

    per_link_queue_polling_scheduler dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_action             (i_action),
        .i_source_link        (i_source_link),
        .i_packet_tag         (i_packet_tag),
        .i_destination        (i_destination),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_served_tag         (o_served_tag),
        .o_served_destination (o_served_destination),
        .o_served_queue       (o_served_queue),
        .o_verdict            (o_verdict),
        .o_last_of_run        (o_last_of_run),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // scheduler shadow
    // ---------------------------------------------------------------

    // queues in the round robin, held to 2..NUM_QUEUES
    function automatic int unsigned link_span();
        int unsigned l;
        l = links_reg;
        if (l < 2) l = 2;
        if (l > NUM_QUEUES) l = NUM_QUEUES;
        return l;
    endfunction

    // node or link number held to 1..link span
    function automatic int unsigned node_clamp(int unsigned v);
        int unsigned l;
        l = link_span();
        if (v < 1) v = 1;
        if (v > l) v = l;
        return v;
    endfunction

    // exhaustive round robin: consume until a packet is forwarded or all is dry
    function automatic void serve_next();
        int unsigned l;
        int unsigned me;
        int unsigned cur;
        bit          found;
        t_served     r;
        l  = link_span();
        me = node_clamp(own_node_reg);
        while (1) begin
            cur   = serve_q;
            found = 1'b0;
            // scan starts at the queue being served, one extra step for the wrap
            if (pending_pkts != 0) begin
                for (int i = 0; i <= NUM_QUEUES; i++) begin
                    if (cur < NUM_QUEUES && q_fill[cur] != 0) begin
                        found = 1'b1;
                        break;
                    end
                    cur = (cur + 1 >= l) ? 0 : cur + 1;
                end
            end
            // nothing reachable, stranded packets included
            if (!found) begin
                sched_idle = 1'b1;
                return;
            end
            serve_q = cur;
            r.tag   = pkt_mem[cur][q_head[cur]][TAG_W-1:0];
            r.dest  = pkt_mem[cur][q_head[cur]][ENTRY_W-1:TAG_W];
            r.queue = cur[QOUT_W-1:0];
            r.last  = 1'b0;
            q_head[cur] = (q_head[cur] + 1 >= QUEUE_DEPTH) ? 0 : q_head[cur] + 1;
            q_fill[cur]--;
            pending_pkts--;
            if (r.dest != me) begin
                // forwarded: busy until send-done
                r.verdict = V_FORWARD;
                run_results.push_back(r);
                return;
            end
            r.verdict = V_CONSUME;
            run_results.push_back(r);
        end
    endfunction

    // expected results of one accepted input transaction
    function automatic void predict_item(logic [ACT_W-1:0] act, logic [NODE_W-1:0] link,
                                         logic [TAG_W-1:0] tag, logic [NODE_W-1:0] dest);
        int unsigned q;
        int unsigned slot;
        t_served     r;
        run_results.delete();
        if (act == ACT_ARRIVE || act == ACT_LOCAL) begin
            q = (act == ACT_ARRIVE) ? node_clamp(link) - 1 : node_clamp(own_node_reg) - 1;
            if (q_fill[q] >= QUEUE_DEPTH) begin
                // full queue: dropped, nothing else moves
                r.tag     = tag;
                r.dest    = dest;
                r.queue   = q[QOUT_W-1:0];
                r.verdict = V_DROP;
                r.last    = 1'b0;
                run_results.push_back(r);
            end else begin
                slot = q_head[q] + q_fill[q];
                if (slot >= QUEUE_DEPTH) slot -= QUEUE_DEPTH;
                pkt_mem[q][slot] = {dest, tag};
                q_fill[q]++;
                pending_pkts++;
                // an idle block starts at the queue just filled
                if (sched_idle) begin
                    serve_q    = q;
                    sched_idle = 1'b0;
                    serve_next();
                end
            end
        end else if (act == ACT_SEND_DONE && !sched_idle) begin
            serve_next();
        end
        if (run_results.size() != 0) run_results[run_results.size() - 1].last = 1'b1;
        foreach (run_results[i]) expected_served.push_back(run_results[i]);
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // one input transaction, with random gaps ahead of it
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [NODE_W-1:0] link,
                             input logic [TAG_W-1:0] tag, input logic [NODE_W-1:0] dest);
        @(negedge i_clk);
        while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_source_link <= link;
        i_packet_tag  <= tag;
        i_destination <= dest;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        predict_item(act, link, tag, dest);
    endtask

    // one register write transaction, block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NODE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_writes++;
        case (idx)
            REG_OWN_NODE:     own_node_reg = data;
            REG_LINKS_IN_USE: links_reg    = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // send-done until the shadow goes idle, then let every result drain
    task automatic bring_idle();
        while (!sched_idle)
            send_item(ACT_SEND_DONE, NODE_W'(0), TAG_W'($urandom()),
                      NODE_W'($urandom_range(0, 15)));
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_served.size() != 0) @(posedge i_clk);
        // a run with no result may still be in the block
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random transaction, mostly well-formed traffic at the current settings
    task automatic random_item();
        int unsigned       pick;
        int unsigned       l;
        int unsigned       me;
        logic [ACT_W-1:0]  act;
        logic [NODE_W-1:0] link;
        logic [NODE_W-1:0] dest;
        l    = link_span();
        me   = node_clamp(own_node_reg);
        pick = $urandom_range(0, 99);
        if (pick < 45)      act = ACT_ARRIVE;
        else if (pick < 62) act = ACT_LOCAL;
        else if (pick < 95) act = ACT_SEND_DONE;
        else                act = ACT_IGNORED;
        link = ($urandom_range(0, 99) < 85) ? NODE_W'($urandom_range(1, l))
                                            : NODE_W'($urandom_range(0, 15));
        // many packets for this node so consume chains build up
        dest = ($urandom_range(0, 99) < 40) ? NODE_W'(me) : NODE_W'($urandom_range(0, 15));
        send_item(act, link, TAG_W'($urandom()), dest);
    endtask

    // ---------------------------------------------------------------
    // result checking and watchdog
    // ---------------------------------------------------------------

    // result side stalls at random
    always @(negedge i_clk)
        i_out_ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);

    // every result transaction against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_served want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_served.size() == 0) begin
                $error("unexpected result: tag %0h queue %0d verdict %0d",
                       o_served_tag, o_served_queue, o_verdict);
                fail_count++;
            end else begin
                want = expected_served.pop_front();
                if (o_served_tag !== want.tag) begin
                    $error("served_tag: expected %0h, got %0h", want.tag, o_served_tag);
                    fail_count++;
                end
                if (o_served_destination !== want.dest) begin
                    $error("served_destination: expected %0d, got %0d",
                           want.dest, o_served_destination);
                    fail_count++;
                end
                if (o_served_queue !== want.queue) begin
                    $error("served_queue: expected %0d, got %0d", want.queue, o_served_queue);
                    fail_count++;
                end
                if (o_verdict !== want.verdict) begin
                    $error("verdict: expected %0d, got %0d", want.verdict, o_verdict);
                    fail_count++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run: expected %0b, got %0b", want.last, o_last_of_run);
                    fail_count++;
                end
                case (want.verdict)
                    V_FORWARD: forwards_seen++;
                    V_CONSUME: consumes_seen++;
                    default:   drops_seen++;
                endcase
            end
        end
    end

    // ends a run that hangs: counts cycles with no transaction of any kind
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("per_link_queue_polling_scheduler regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset registers, ignored transactions, consume and forward from idle
    task automatic test_reset_defaults();
        send_item(ACT_LOCAL, 4'd0, 16'h0001, 4'd1);      // consumed at once, back idle
        send_item(ACT_SEND_DONE, 4'd0, 16'h0000, 4'd0);  // send-done while idle
        send_item(ACT_IGNORED, 4'd15, 16'hFFFF, 4'd15);  // unused action
        send_item(ACT_LOCAL, 4'd15, 16'h0000, 4'd8);     // forwarded, now busy
        send_item(ACT_SEND_DONE, 4'd1, 16'h5555, 4'd3);  // nothing left, idle
        bring_idle();
    endtask

    // fill one queue past depth, then one send-done drains it as a consume chain
    task automatic test_full_queue();
        send_item(ACT_ARRIVE, 4'd0, 16'h1234, 4'd15);    // link 0 saturates to queue 0
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_item(ACT_ARRIVE, 4'd15, TAG_W'(16'hA000 + i), 4'd1);
        send_item(ACT_ARRIVE, 4'd15, 16'hFFFF, 4'd1);    // queue full, dropped
        send_item(ACT_SEND_DONE, 4'd0, 16'h0000, 4'd0);
        bring_idle();
    endtask

    // exhaustive service: stay on a queue until dry, then next non-empty one
    task automatic test_round_robin();
        send_item(ACT_ARRIVE, 4'd2, 16'h0201, 4'd3);
        send_item(ACT_ARRIVE, 4'd5, 16'h0501, 4'd4);
        send_item(ACT_ARRIVE, 4'd7, 16'h0701, 4'd5);
        send_item(ACT_ARRIVE, 4'd2, 16'h0202, 4'd6);
        send_item(ACT_ARRIVE, 4'd5, 16'h0502, 4'd1);     // consumed on the way
        repeat (4) send_item(ACT_SEND_DONE, 4'd0, 16'h0000, 4'd0);
        bring_idle();
    endtask

    // register values below and above range, and an unmapped index
    task automatic test_register_extremes();
        write_reg(REG_OWN_NODE, 4'd0);
        write_reg(REG_LINKS_IN_USE, 4'd0);
        write_reg(REG_UNMAPPED, 4'd15);
        send_item(ACT_ARRIVE, 4'd9, 16'h0005, 4'd1);     // link saturates to 2
        bring_idle();
        write_reg(REG_OWN_NODE, 4'd15);
        write_reg(REG_LINKS_IN_USE, 4'd15);
        send_item(ACT_LOCAL, 4'd0, 16'h00AA, 4'd8);      // local queue of node 8
        bring_idle();
    endtask

    // random traffic over several register settings, one phase with no gaps
    task automatic test_random_traffic();
        logic [NODE_W-1:0] own;
        logic [NODE_W-1:0] links;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            bring_idle();
            case (ph)
                0: begin own = 4'd0;  links = 4'd0;  end
                1: begin own = 4'd15; links = 4'd15; end
                2: begin own = 4'd8;  links = 4'd2;  end
                3: begin own = 4'd1;  links = 4'd8;  end
                default: begin
                    own   = NODE_W'($urandom_range(0, 15));
                    links = NODE_W'($urandom_range(0, 15));
                end
            endcase
            write_reg(REG_OWN_NODE, own);
            write_reg(REG_LINKS_IN_USE, links);
            steady_run = (ph == 3);
            repeat (ITEMS_PER_PHASE) random_item();
        end
        steady_run = 1'b0;
        bring_idle();
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------
    initial begin
        // shadow starts from the reset state
        foreach (q_head[i]) begin
            q_head[i] = 0;
            q_fill[i] = 0;
        end
        pending_pkts  = 0;
        serve_q       = 0;
        sched_idle    = 1'b1;
        own_node_reg  = OWN_NODE_RST;
        links_reg     = LINKS_IN_USE_RST;
        steady_run    = 1'b0;
        quiet_cycles  = 0;
        fail_count    = 0;
        items_sent    = 0;
        cfg_writes    = 0;
        forwards_seen = 0;
        consumes_seen = 0;
        drops_seen    = 0;

        // hold the synchronous reset, then release it
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_full_queue();
        test_round_robin();
        test_register_extremes();
        test_random_traffic();

        if (expected_served.size() != 0) begin
            $error("%0d results never came out", expected_served.size());
            fail_count++;
        end
        $display("covered %0d input transactions and %0d register writes",
                 items_sent, cfg_writes);
        $display("results: %0d forwarded, %0d consumed, %0d dropped, %0d mismatches",
                 forwards_seen, consumes_seen, drops_seen, fail_count);
        if (fail_count == 0) begin
            $display("per_link_queue_polling_scheduler regression: pass");
        end else begin
            $display("per_link_queue_polling_scheduler regression: fail");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/plq_pkg.sv
hw/rtl/plq_store.sv
hw/rtl/plq_ctrl.sv
hw/rtl/per_link_queue_polling_scheduler.sv
test/per_link_queue_polling_scheduler_tb.sv
